// File: rtl/ptm_pkg.sv
// Shared types and constants for the pupil threshold mask block.
// No dependencies; ptm_front, ptm_back and the top file import this package.
package ptm_pkg;

    localparam int COUNT_W   = 21;   // frame position and mask count
    localparam int CFG_W     = 16;   // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int GEOM_W    = 11;   // width and height registers
    localparam int FRAC_W    = 16;

    localparam logic [GEOM_W-1:0] RESET_DIM  = 11'd1024;
    localparam logic [FRAC_W-1:0] RESET_FRAC = 16'd26214;

    localparam logic OP_CALIB    = 1'b0;
    localparam logic OP_MASK     = 1'b1;
    localparam logic KIND_THRESH = 1'b0;
    localparam logic KIND_MASK   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FRAC   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,   // write a central-row pixel
        CMD_SELECT = 2'd1,   // end of calibration: optional store, then rank select
        CMD_MASK   = 2'd2    // judge a mask-pass pixel
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic store;
        logic last;
    } ctl_t;

    typedef enum logic [2:0] {
        F_RUN  = 3'b001,
        F_MULT = 3'b010,
        F_DIV  = 3'b100
    } front_state_t;

    typedef enum logic [3:0] {
        B_RUN  = 4'b0001,
        B_RANK = 4'b0010,
        B_SCAN = 4'b0100,
        B_EMIT = 4'b1000
    } back_state_t;

endpackage

// File: rtl/ptm_queue.sv
// Small FIFO between the front end and the back end.
// Depends on nothing but its parameters.
module ptm_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/ptm_front.sv
// Front end: configuration registers, frame position tracking and
// classification of pixels into queue commands. Uses ptm_pkg.
module ptm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [PIXEL_BITS-1:0]         s_pixel,
    input  logic                          q_full,
    output logic                          q_push,
    output ptm_pkg::ctl_t                 q_ctl,
    output logic [COL_W-1:0]              q_col,
    output logic [PIXEL_BITS-1:0]         q_pixel,
    output logic [WW-1:0]                 width_eff,
    output logic [ptm_pkg::FRAC_W-1:0]    frac
);
    import ptm_pkg::*;

    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int FW    = WW + HW;
    localparam int ITW   = $clog2(COUNT_W + 1);

    front_state_t state_reg, state_next;

    logic [GEOM_W-1:0]  width_reg, height_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [FW-1:0]      frame_reg;
    logic [COUNT_W-1:0] pos_reg, row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [WW-1:0]      rem_reg, rem_next;
    logic [ITW-1:0]     iter_reg;
    logic [WW:0]        trial;
    logic               accept, is_last, central, geom_write;

    // clamp geometry to 1..maximum
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    assign width_eff = w_eff;
    assign frac      = frac_reg;

    assign s_ready = (state_reg == F_RUN) && !q_full;
    assign accept  = s_valid && s_ready;
    assign is_last = (32'(pos_reg) >= (32'(frame_reg) - 32'd1));
    assign central = (32'(row_reg) == 32'(h_eff >> 1));

    // calibration pixels off the central row matter only as the frame's end
    assign q_push        = accept && ((s_operation == OP_MASK) || central || is_last);
    assign q_ctl.cmd     = (s_operation == OP_MASK) ? CMD_MASK :
                           (is_last ? CMD_SELECT : CMD_STORE);
    assign q_ctl.store   = (s_operation == OP_CALIB) && central;
    assign q_ctl.last    = is_last;
    assign q_col         = col_reg;
    assign q_pixel       = s_pixel;

    assign geom_write = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    // restoring division of the position by the width, one quotient bit a cycle
    always_comb begin
        trial = {rem_reg, quo_reg[COUNT_W-1]} - {1'b0, w_eff};
        if (!trial[WW]) begin
            rem_next = trial[WW-1:0];
            quo_next = {quo_reg[COUNT_W-2:0], 1'b1};
        end else begin
            rem_next = {rem_reg[WW-2:0], quo_reg[COUNT_W-1]};
            quo_next = {quo_reg[COUNT_W-2:0], 1'b0};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_RUN:   state_next = F_RUN;
            F_MULT:  state_next = F_DIV;
            F_DIV:   if (iter_reg == ITW'(1)) state_next = F_RUN;
            default: state_next = F_MULT;
        endcase
        if (geom_write) begin
            state_next = F_MULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_MULT;
            width_reg  <= RESET_DIM;
            height_reg <= RESET_DIM;
            frac_reg   <= RESET_FRAC;
            pos_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data[GEOM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[GEOM_W-1:0];
                    REG_FRAC:   frac_reg   <= cfg_data[FRAC_W-1:0];
                    default:    ;
                endcase
            end
            if (accept) begin
                if (is_last) begin
                    pos_reg <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                    if (32'(col_reg) + 32'd1 == 32'(w_eff)) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
            if ((state_reg == F_DIV) && (iter_reg == ITW'(1))) begin
                row_reg <= quo_next;
                col_reg <= rem_next[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_MULT) begin
            frame_reg <= FW'(w_eff) * FW'(h_eff);
            quo_reg   <= pos_reg;
            rem_reg   <= '0;
            iter_reg  <= ITW'(COUNT_W);
        end else if (state_reg == F_DIV) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            iter_reg <= iter_reg - 1'b1;
        end
    end

endmodule

// File: rtl/ptm_back.sv
// Back end: central-row memory, bitwise rank selection, mask judgment,
// pixel count and the output register. Uses ptm_pkg.
module ptm_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [WW-1:0]              width_eff,
    input  logic [ptm_pkg::FRAC_W-1:0] frac,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  ptm_pkg::ctl_t              q_ctl,
    input  logic [COL_W-1:0]           q_col,
    input  logic [PIXEL_BITS-1:0]      q_pixel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_kind,
    output logic                       m_mask_bit,
    output logic [PIXEL_BITS-1:0]      m_threshold,
    output logic [ptm_pkg::COUNT_W-1:0] m_pupil_count,
    output logic                       m_last
);
    import ptm_pkg::*;

    localparam int PW = FRAC_W + WW;

    back_state_t state_reg, state_next;

    logic [PIXEL_BITS-1:0] row_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic [COL_W-1:0]      scan_addr_reg;
    logic                  issuing_reg, rd_vld_reg, rd_last_reg;
    logic [PIXEL_BITS-1:0] prefix_reg, bmask_reg, hmask_reg, prefix_new;
    logic [WW-1:0]         rank_reg, cnt_reg, cnt_sum, rank_raw;
    logic [PW-1:0]         prod;
    logic [PIXEL_BITS-1:0] thr_reg;
    logic [COUNT_W-1:0]    inside_reg, inside_new;
    logic                  out_free, mask_bit, qual, wr_en, emit_mask, emit_thr;

    logic                  m_valid_reg, m_kind_reg, m_mask_bit_reg, m_last_reg;
    logic [PIXEL_BITS-1:0] m_threshold_reg;
    logic [COUNT_W-1:0]    m_pupil_count_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign mask_bit = (q_pixel >= thr_reg);
    assign inside_new = inside_reg + COUNT_W'(mask_bit);

    assign emit_mask = (state_reg == B_RUN) && !q_empty && (q_ctl.cmd == CMD_MASK) && out_free;
    assign emit_thr  = (state_reg == B_EMIT) && out_free;
    assign q_pop     = (state_reg == B_RUN) && !q_empty &&
                       ((q_ctl.cmd != CMD_MASK) || out_free);
    assign wr_en     = q_pop && q_ctl.store &&
                       ((q_ctl.cmd == CMD_STORE) || (q_ctl.cmd == CMD_SELECT));

    assign prod     = PW'(frac) * PW'(width_eff);
    assign rank_raw = prod[PW-1:FRAC_W];

    // element counts below the candidate when its higher bits match and this bit is 0
    assign qual = rd_vld_reg && (((rd_data_reg ^ prefix_reg) & hmask_reg) == '0) &&
                  ((rd_data_reg & bmask_reg) == '0);
    assign cnt_sum    = cnt_reg + WW'(qual);
    assign prefix_new = (rank_reg < cnt_sum) ? prefix_reg : (prefix_reg | bmask_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[q_col] <= q_pixel;
        end
        rd_data_reg <= row_mem[scan_addr_reg];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_RUN:   if (q_pop && (q_ctl.cmd == CMD_SELECT)) state_next = B_RANK;
            B_RANK:  state_next = B_SCAN;
            B_SCAN:  if (rd_last_reg && bmask_reg[0]) state_next = B_EMIT;
            B_EMIT:  if (out_free) state_next = B_RUN;
            default: state_next = B_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_RUN;
            thr_reg     <= '0;
            inside_reg  <= '0;
            issuing_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= issuing_reg;
            rd_last_reg <= issuing_reg && (32'(scan_addr_reg) + 32'd1 == 32'(width_eff));
            if (issuing_reg) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                if (32'(scan_addr_reg) + 32'd1 == 32'(width_eff)) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (state_reg == B_RANK) begin
                rank_reg      <= (rank_raw > width_eff - 1'b1) ? width_eff - 1'b1 : rank_raw;
                prefix_reg    <= '0;
                bmask_reg     <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
                hmask_reg     <= '0;
                cnt_reg       <= '0;
                scan_addr_reg <= '0;
                issuing_reg   <= 1'b1;
            end
            if (state_reg == B_SCAN) begin
                if (rd_last_reg) begin
                    prefix_reg <= prefix_new;
                    if (!(rank_reg < cnt_sum)) begin
                        rank_reg <= rank_reg - cnt_sum;
                    end
                    if (bmask_reg[0]) begin
                        thr_reg <= prefix_new;
                    end else begin
                        // advance to the next lower bit
                        bmask_reg     <= bmask_reg >> 1;
                        hmask_reg     <= hmask_reg | bmask_reg;
                        cnt_reg       <= '0;
                        scan_addr_reg <= '0;
                        issuing_reg   <= 1'b1;
                    end
                end else begin
                    cnt_reg <= cnt_sum;
                end
            end
            if (emit_mask) begin
                inside_reg <= q_ctl.last ? '0 : inside_new;
            end else if (q_pop && q_ctl.last) begin
                // a frame that ends on a calibration pixel restarts the count too
                inside_reg <= '0;
            end
            if (emit_mask || emit_thr) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_mask) begin
            m_kind_reg        <= KIND_MASK;
            m_mask_bit_reg    <= mask_bit;
            m_threshold_reg   <= thr_reg;
            m_pupil_count_reg <= q_ctl.last ? inside_new : '0;
            m_last_reg        <= q_ctl.last;
        end else if (emit_thr) begin
            m_kind_reg        <= KIND_THRESH;
            m_mask_bit_reg    <= 1'b0;
            m_threshold_reg   <= thr_reg;
            m_pupil_count_reg <= '0;
            m_last_reg        <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_mask_bit    = m_mask_bit_reg;
    assign m_threshold   = m_threshold_reg;
    assign m_pupil_count = m_pupil_count_reg;
    assign m_last        = m_last_reg;

    a_pop_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == B_RUN))
        else $error("queue popped outside run state");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SCAN) |-> (rank_reg < width_eff))
        else $error("rank out of row range");

    a_scan_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_last_reg |-> !issuing_reg)
        else $error("pass ended while reads still issued");

endmodule

// File: rtl/pupil_threshold_mask_top.sv
// Mask-pass pixels and central-row calibration pixels go through at one per cycle
// while the queue has room and the output is not stalled. After the last calibration
// pixel the threshold is selected bit by bit: PIXEL_BITS passes over the stored row,
// one memory read per cycle, during which later pixels queue up and then stall. A
// width or height write makes the input not ready while the frame size and the row
// and column of the current position are recomputed (also after reset). Holds
// ptm_front, ptm_queue and ptm_back; uses ptm_pkg.
module pupil_threshold_mask_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [PIXEL_BITS-1:0]         s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic                          m_mask_bit,
    output logic [PIXEL_BITS-1:0]         m_threshold,
    output logic [ptm_pkg::COUNT_W-1:0]   m_pupil_count,
    output logic                          m_last
);
    import ptm_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DATA_W = $bits(ctl_t) + COL_W + PIXEL_BITS;

    logic                  q_push, q_pop, q_full, q_empty;
    ctl_t                  push_ctl, pop_ctl;
    logic [COL_W-1:0]      push_col, pop_col;
    logic [PIXEL_BITS-1:0] push_pixel, pop_pixel;
    logic [WW-1:0]         width_eff;
    logic [FRAC_W-1:0]     frac;

    ptm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS),
        .WW        (WW),
        .COL_W     (COL_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .s_pixel    (s_pixel),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctl      (push_ctl),
        .q_col      (push_col),
        .q_pixel    (push_pixel),
        .width_eff  (width_eff),
        .frac       (frac)
    );

    ptm_queue #(
        .DATA_W(DATA_W),
        .DEPTH (4)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({push_ctl, push_col, push_pixel}),
        .pop      (q_pop),
        .pop_data ({pop_ctl, pop_col, pop_pixel}),
        .full     (q_full),
        .empty    (q_empty)
    );

    ptm_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS),
        .WW        (WW),
        .COL_W     (COL_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .width_eff    (width_eff),
        .frac         (frac),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_ctl        (pop_ctl),
        .q_col        (pop_col),
        .q_pixel      (pop_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_mask_bit   (m_mask_bit),
        .m_threshold  (m_threshold),
        .m_pupil_count(m_pupil_count),
        .m_last       (m_last)
    );

endmodule

// File: dv/testbench.sv
// Testbench for pupil_threshold_mask_top: threshold selection over the central row and
// the binary mask pass, checked against a predictor held in a small scoreboard class.
// Depends on ptm_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module testbench;
    import ptm_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int PIX_W      = 16;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int SETTLE     = 60;

    typedef struct packed {
        logic               kind;
        logic               mask_bit;
        logic [PIX_W-1:0]   threshold;
        logic [COUNT_W-1:0] pupil_count;
        logic               last;
    } mask_result_t;

    class pupil_mask_predictor;
        int unsigned    width_reg  = 1024;
        int unsigned    height_reg = 1024;
        int unsigned    frac_reg   = 26214;
        logic [PIX_W-1:0] row_pix[MAXW];
        bit             row_seen[MAXW];
        int unsigned    pos;
        int unsigned    mask_cnt;
        logic [PIX_W-1:0] thresh = '0;
        mask_result_t   pending[$];
        int             errors;

        function void set_reg(cfg_reg_t idx, int unsigned v);
            case (idx)
                REG_WIDTH:  width_reg  = v & 'h7FF;
                REG_HEIGHT: height_reg = v & 'h7FF;
                REG_FRAC:   frac_reg   = v & 'hFFFF;
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAXW) return MAXW;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAXH) return MAXH;
            return height_reg;
        endfunction

        function bit at_frame_end();
            return pos >= eff_w() * eff_h() - 1;
        endfunction

        // A frame may end on a calibration pixel only once every column of the row is known.
        function bit calib_safe();
            if (!at_frame_end()) return 1;
            for (int i = 0; i < eff_w(); i++)
                if (!row_seen[i]) return 0;
            return 1;
        endfunction

        function logic [PIX_W-1:0] pick_rank(int unsigned w);
            logic [PIX_W-1:0] vals[$];
            longint unsigned  r;
            for (int i = 0; i < w; i++) vals.push_back(row_pix[i]);
            vals.sort();
            r = (longint'(frac_reg) * w) >> 16;
            if (r > w - 1) r = w - 1;
            return vals[r];
        endfunction

        function void note_pixel(logic op, logic [PIX_W-1:0] pix);
            int unsigned  w;
            int unsigned  h;
            bit           fin;
            mask_result_t e;
            w   = eff_w();
            h   = eff_h();
            fin = at_frame_end();
            e   = '0;
            if (op == OP_CALIB) begin
                if (pos / w == h / 2) begin
                    row_pix[pos % w]  = pix;
                    row_seen[pos % w] = 1;
                end
                if (fin) begin
                    thresh      = pick_rank(w);
                    e.kind      = KIND_THRESH;
                    e.threshold = thresh;
                    pending.push_back(e);
                end
            end else begin
                e.kind      = KIND_MASK;
                e.mask_bit  = pix >= thresh;
                if (e.mask_bit) mask_cnt = (mask_cnt + 1) & 'h1FFFFF;
                e.threshold = thresh;
                e.last      = fin;
                e.pupil_count = fin ? mask_cnt[COUNT_W-1:0] : '0;
                pending.push_back(e);
            end
            if (fin) begin
                pos      = 0;
                mask_cnt = 0;
            end else begin
                pos = (pos + 1) & 'h1FFFFF;
            end
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_result(mask_result_t got);
            mask_result_t e;
            if (pending.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, e.kind));
            if (got.mask_bit !== e.mask_bit)
                report($sformatf("mask_bit %0d, expected %0d", got.mask_bit, e.mask_bit));
            if (got.threshold !== e.threshold)
                report($sformatf("threshold %0d, expected %0d", got.threshold, e.threshold));
            if (got.pupil_count !== e.pupil_count)
                report($sformatf("pupil_count %0d, expected %0d",
                                 got.pupil_count, e.pupil_count));
            if (got.last !== e.last)
                report($sformatf("last %0d, expected %0d", got.last, e.last));
        endfunction
    endclass

    logic                  aclk        = 0;
    logic                  aresetn     = 0;
    logic                  cfg_we      = 0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  s_valid     = 0;
    logic                  s_ready;
    logic                  s_operation = 0;
    logic [PIX_W-1:0]      s_pixel     = '0;
    logic                  m_valid;
    logic                  m_ready     = 0;
    logic                  m_kind;
    logic                  m_mask_bit;
    logic [PIX_W-1:0]      m_threshold;
    logic [COUNT_W-1:0]    m_pupil_count;
    logic                  m_last;

    pupil_mask_predictor predictor;
    int  cycles;
    int  pixels_sent;
    int  out_stall;
    bit  in_idle_on;
    bit  out_idle_on;

    pupil_threshold_mask_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_mask_bit(m_mask_bit), .m_threshold(m_threshold),
        .m_pupil_count(m_pupil_count), .m_last(m_last)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check accepted results, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            predictor.check_result({m_kind, m_mask_bit, m_threshold, m_pupil_count, m_last});
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_ready   <= 0;
        end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
            out_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
            m_ready   <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    function automatic int gap_len();
        int unsigned r;
        if (!in_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        if (r < 36) return PIX_W'(predictor.thresh + $urandom_range(0, 2) - 1);
        return PIX_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_pixel(logic op, logic [PIX_W-1:0] pix);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid     <= 1;
        s_operation <= op;
        s_pixel     <= pix;
        do @(posedge aclk); while (!s_ready);
        predictor.note_pixel(op, pix);
        pixels_sent++;
    endtask

    // Hold the sender until every expected result is in, then let the pipeline settle.
    task automatic drain();
        s_valid <= 0;
        while (predictor.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic setup(int unsigned w, int unsigned h, int unsigned f);
        drain();
        cfg_we    <= 1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w[CFG_W-1:0];
        predictor.set_reg(REG_WIDTH, w);
        @(posedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h[CFG_W-1:0];
        predictor.set_reg(REG_HEIGHT, h);
        @(posedge aclk);
        cfg_index <= REG_FRAC;
        cfg_data  <= f[CFG_W-1:0];
        predictor.set_reg(REG_FRAC, f);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic run_pass(logic op, int n, int noise);
        logic o;
        for (int i = 0; i < n; i++) begin
            o = op;
            if ($urandom_range(0, 99) < noise) o = ~o;
            if (o == OP_CALIB && !predictor.calib_safe()) o = OP_MASK;
            if ($urandom_range(0, 999) == 0) drain();
            send_pixel(o, rand_pixel());
        end
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned f, int noise);
        int frame;
        setup(w, h, f);
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
        frame = predictor.eff_w() * predictor.eff_h();
        run_pass(OP_CALIB, frame, noise);
        repeat ($urandom_range(1, 2)) run_pass(OP_MASK, frame, noise);
        // leave a partial frame so the next geometry lands mid-frame
        if ($urandom_range(0, 4) == 0)
            run_pass(1'($urandom_range(0, 1)), $urandom_range(1, frame), noise);
    endtask

    function automatic int unsigned rand_frac();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    initial begin
        predictor = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed: rank extremes, pixel extremes, clamped geometry
        setup(3, 1, 0);
        send_pixel(OP_CALIB, 16'hFFFF);
        send_pixel(OP_CALIB, 16'h0000);
        send_pixel(OP_CALIB, 16'h8000);
        send_pixel(OP_MASK, 16'h0000);
        send_pixel(OP_MASK, 16'hFFFF);
        send_pixel(OP_MASK, 16'h8000);
        setup(3, 1, 65535);
        send_pixel(OP_CALIB, 16'h0001);
        send_pixel(OP_CALIB, 16'h0003);
        send_pixel(OP_CALIB, 16'h0002);
        send_pixel(OP_MASK, 16'h0002);
        send_pixel(OP_MASK, 16'h0003);
        send_pixel(OP_MASK, 16'hFFFF);
        setup(0, 0, 26214);
        send_pixel(OP_CALIB, 16'h7777);
        send_pixel(OP_MASK, 16'h7776);
        send_pixel(OP_MASK, 16'h7777);
        setup(2, 3, 32768);
        send_pixel(OP_CALIB, 16'h0010);
        send_pixel(OP_MASK, 16'h0020);
        send_pixel(OP_CALIB, 16'h0030);
        send_pixel(OP_CALIB, 16'h0005);
        send_pixel(OP_CALIB, 16'h0040);
        send_pixel(OP_CALIB, 16'h0050);
        send_pixel(OP_MASK, 16'h0030);

        // largest geometry, values above the maximum; leave the mask frames open
        setup(2047, 1, 26214);
        run_pass(OP_CALIB, MAXW, 0);
        run_pass(OP_MASK, 64, 0);
        setup(1, 2047, 65535);
        run_pass(OP_MASK, 64, 0);

        while (pixels_sent < 1500)
            run_phase(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10),
                      $urandom_range(0, 4), rand_frac(),
                      ($urandom_range(0, 3) == 0) ? 15 : 0);

        s_valid <= 0;
        out_idle_on = 0;
        while (predictor.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        while (predictor.pending.size() != 0) begin
            void'(predictor.pending.pop_front());
            predictor.report("expected result never arrived");
        end
        if (predictor.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
